// ===== src/iq_audio_demodulator_defines.svh =====
// assertion macros shared by the demodulator rtl
// no dependencies
`ifndef IQ_AUDIO_DEMODULATOR_DEFINES_SVH
`define IQ_AUDIO_DEMODULATOR_DEFINES_SVH

// property holds at every clock edge outside reset
`define IQD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication checked in the next cycle
`define IQD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/iqd_pkg.sv =====
// types and constants of the iq audio demodulator
// no dependencies
`default_nettype none
package iqd_pkg;

  typedef enum logic [2:0] {
    MODE_USB = 3'd0,
    MODE_LSB = 3'd1,
    MODE_CW  = 3'd2,
    MODE_AM  = 3'd3,
    MODE_NFM = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    REG_MODE   = 3'd0,
    REG_RATE   = 3'd1,
    REG_DC     = 3'd2,
    REG_LP     = 3'd3,
    REG_BFO    = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_CORDIC,
    ST_GAIN,
    ST_POST,
    ST_LPMUL,
    ST_LPUPD,
    ST_OUT
  } state_t;

  // item handed from the front to the back
  typedef struct packed {
    logic signed [7:0] i_s;
    logic signed [7:0] q_s;
    logic [2:0]        mode;
  } item_t;

  localparam int ATAN_N = 24;
  localparam logic signed [27:0] PI_Q23   = 28'sd26353589;
  localparam logic signed [31:0] INVK_Q30 = 32'sd652032874;
  localparam logic signed [18:0] GAIN_NFM = 19'sd183501;
  localparam logic signed [18:0] GAIN_SSB = 19'sd111411;
  localparam logic [24:0] CW_FLOOR  = 25'd335544;
  localparam logic [24:0] ONE_Q24   = 25'd16777216;
  localparam logic [19:0] DC_MIN    = 20'd17;
  localparam logic [19:0] DC_MAX    = 20'd838861;
  localparam logic signed [27:0] LP_MAX = 28'sd134217727;
  localparam logic signed [27:0] LP_MIN = -28'sd134217728;

  function automatic logic [22:0] atan_q23(input logic [4:0] k);
    case (k)
      5'd0: atan_q23 = 23'd6588397;
      5'd1: atan_q23 = 23'd3889358;
      5'd2: atan_q23 = 23'd2055030;
      5'd3: atan_q23 = 23'd1043165;
      5'd4: atan_q23 = 23'd523607;
      5'd5: atan_q23 = 23'd262059;
      5'd6: atan_q23 = 23'd131061;
      5'd7: atan_q23 = 23'd65535;
      5'd8: atan_q23 = 23'd32768;
      5'd9: atan_q23 = 23'd16384;
      5'd10: atan_q23 = 23'd8192;
      5'd11: atan_q23 = 23'd4096;
      5'd12: atan_q23 = 23'd2048;
      5'd13: atan_q23 = 23'd1024;
      5'd14: atan_q23 = 23'd512;
      5'd15: atan_q23 = 23'd256;
      5'd16: atan_q23 = 23'd128;
      5'd17: atan_q23 = 23'd64;
      5'd18: atan_q23 = 23'd32;
      5'd19: atan_q23 = 23'd16;
      5'd20: atan_q23 = 23'd8;
      5'd21: atan_q23 = 23'd4;
      5'd22: atan_q23 = 23'd2;
      5'd23: atan_q23 = 23'd1;
      default: atan_q23 = 23'd0;
    endcase
  endfunction

endpackage
`default_nettype wire

// ===== src/iqd_front.sv =====
// front end: takes iq transfers, tags them with the mode, two-entry queue
// depends on iqd_pkg
`default_nettype none
module iqd_front (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_ready,
  input  wire signed [7:0]  in_i,
  input  wire signed [7:0]  in_q,
  input  wire [2:0]         mode,
  output logic              q_valid,
  input  wire               q_ready,
  output iqd_pkg::item_t    q_item
);
  import iqd_pkg::*;

  item_t mem [2];
  logic  wr_ptr, rd_ptr;
  logic [1:0] count;
  logic  push, pop;

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;
  assign q_item   = mem[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= '{i_s: in_i, q_s: in_q, mode: mode};
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  `include "iq_audio_demodulator_defines.svh"
  `IQD_ASSERT(a_count_range, count <= 2'd2, "queue count out of range")
  `IQD_ASSERT_NEXT(a_full_push, (count == 2'd2) && !pop, count == 2'd2, "full queue lost entry")
  `IQD_ASSERT_NEXT(a_empty_stay, (count == 2'd0) && !push, !q_valid, "empty queue showed data")
endmodule
`default_nettype wire

// ===== src/iqd_back.sv =====
// back end: demodulation with iterated cordic, low-pass, resampler, output register
// depends on iqd_pkg
`default_nettype none
module iqd_back #(
  parameter int CORDIC_STAGES = 16,
  parameter int AUDIO_RATE_HZ = 48000
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               q_valid,
  output logic              q_ready,
  input  iqd_pkg::item_t    q_item,
  input  wire [24:0]        input_rate_hz,
  input  wire [19:0]        dc_track_alpha,
  input  wire [24:0]        lowpass_alpha,
  input  wire [25:0]        bfo_phase_step,
  output logic              out_valid,
  input  wire               out_ready,
  output logic signed [15:0] out_audio
);
  import iqd_pkg::*;

  localparam int NST = (CORDIC_STAGES < ATAN_N) ? CORDIC_STAGES : ATAN_N;
  localparam logic [4:0] LAST_K = 5'(NST - 1);
  localparam logic [24:0] AUDIO = 25'(AUDIO_RATE_HZ);

  state_t state, state_next;
  item_t  it;
  logic [2:0] md;

  // cordic working registers
  logic signed [35:0] cx, cy;
  logic signed [31:0] cz;
  logic        vect;
  logic [4:0]  k;
  logic        zero_out;
  logic signed [31:0] base;

  // persistent state
  logic signed [7:0]  prev_i, prev_q;
  logic [23:0]        dc_level;
  logic signed [27:0] lowpass_value;
  logic [31:0]        bfo_phase;
  logic [24:0]        resample_acc;

  // products and intermediate values
  logic signed [63:0] prod;
  logic signed [39:0] dval;
  logic signed [27:0] d_clamped;
  logic signed [29:0] lp_diff;
  logic [24:0]        lp_a;
  logic               emit;

  assign md = it.mode;

  function automatic logic signed [63:0] rshr64(input logic signed [63:0] v, input int s);
    rshr64 = (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    q_ready    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        q_ready = !out_valid || out_ready;
        if (q_valid && q_ready) state_next = ST_PREP;
      end
      ST_PREP:   state_next = (md == MODE_CW || md == MODE_AM || md == MODE_NFM) ?
                              ST_CORDIC : ST_POST;
      ST_CORDIC: if (k == LAST_K) state_next = ST_GAIN;
      ST_GAIN:   state_next = ST_POST;
      ST_POST:   state_next = ST_LPMUL;
      ST_LPMUL:  state_next = ST_LPUPD;
      ST_LPUPD:  state_next = ST_OUT;
      ST_OUT:    state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    logic signed [35:0] xi, yi, dx, dy;
    logic signed [31:0] ph_s;
    logic [31:0] ph, adj;
    logic flip;
    logic signed [17:0] re, im;
    logic signed [39:0] dcdiff;
    logic signed [63:0] tmp;
    logic signed [31:0] dcn;
    logic dir;
    logic signed [63:0] acc_sum;
    logic signed [55:0] lp_prod;
    xi = 36'(it.i_s) <<< 16;
    yi = 36'(it.q_s) <<< 16;
    ph = bfo_phase;
    flip = ph[31] ^ ph[30];
    adj = flip ? ph - 32'h80000000 : ph;
    ph_s = $signed(adj);
    re = 18'(prev_i * it.i_s) + 18'(prev_q * it.q_s);
    im = 18'(prev_i * it.q_s) - 18'(prev_q * it.i_s);
    dx = cy >>> k;
    dy = cx >>> k;
    dir = vect ? (cy >= 0) : (cz >= 0);
    dcdiff = 0; tmp = 0; dcn = 0; acc_sum = 0; lp_prod = 0;
    if (rst) begin
      prev_i <= '0; prev_q <= '0; dc_level <= '0; lowpass_value <= '0;
      bfo_phase <= '0; resample_acc <= '0; out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: if (q_valid && q_ready) it <= q_item;
        ST_PREP: begin
          k <= '0;
          zero_out <= 1'b0;
          base <= '0;
          if (md == MODE_CW) begin
            vect <= 1'b0;
            cx <= flip ? -xi : xi;
            cy <= flip ? -yi : yi;
            cz <= 32'(rshr64(64'(ph_s) * 64'(PI_Q23), 31));
            bfo_phase <= bfo_phase + 32'(bfo_phase_step);
          end else if (md == MODE_AM) begin
            vect <= 1'b1;
            cx <= (it.i_s < 0) ? -xi : xi;
            cy <= yi;
            cz <= '0;
          end else if (md == MODE_NFM) begin
            vect <= 1'b1;
            cz <= '0;
            zero_out <= (prev_i == 0 && prev_q == 0) || (re == 0 && im == 0);
            if (re < 0) begin
              base <= (im >= 0) ? 32'(PI_Q23) : -32'(PI_Q23);
              cx <= -(36'(re) <<< 16);
              cy <= -(36'(im) <<< 16);
            end else begin
              cx <= 36'(re) <<< 16;
              cy <= 36'(im) <<< 16;
            end
            prev_i <= it.i_s;
            prev_q <= it.q_s;
          end else if (md == MODE_LSB) begin
            prod <= 64'(32'(it.i_s) + 32'(it.q_s)) * 64'(GAIN_SSB);
          end else begin
            prod <= 64'(32'(it.i_s) - 32'(it.q_s)) * 64'(GAIN_SSB);
          end
        end
        ST_CORDIC: begin
          // one micro-rotation per cycle
          if (dir) begin
            cx <= vect ? cx + dx : cx - dx;
            cy <= vect ? cy - dy : cy + dy;
          end else begin
            cx <= vect ? cx - dx : cx + dx;
            cy <= vect ? cy + dy : cy - dy;
          end
          if (dir) cz <= vect ? cz + 32'(atan_q23(k)) : cz - 32'(atan_q23(k));
          else     cz <= vect ? cz - 32'(atan_q23(k)) : cz + 32'(atan_q23(k));
          k <= k + 5'd1;
        end
        ST_GAIN: begin
          if (md == MODE_NFM) prod <= 64'(base + cz) * 64'(GAIN_NFM);
          else                prod <= 64'(cx) * 64'(INVK_Q30);
        end
        ST_POST: begin
          if (md == MODE_CW) begin
            dval <= 40'(rshr64(prod, 30)) * 40'sd3;
          end else if (md == MODE_AM) begin
            tmp = rshr64(prod, 30);
            dcdiff = 40'(tmp) - 40'($signed({1'b0, dc_level}));
            tmp = rshr64(64'((dc_track_alpha < DC_MIN) ? DC_MIN :
                  (dc_track_alpha > DC_MAX) ? DC_MAX : dc_track_alpha) * 64'(dcdiff), 24);
            dcn = 32'($signed({1'b0, dc_level})) + 32'(tmp);
            if (dcn < 0) dcn = 0;
            if (dcn > 32'sd16777215) dcn = 32'sd16777215;
            dc_level <= dcn[23:0];
            dval <= (40'(rshr64(prod, 30)) - 40'(dcn)) * 40'sd8;
          end else if (md == MODE_NFM) begin
            dval <= zero_out ? 40'sd0 : 40'(rshr64(prod, 16));
          end else begin
            dval <= 40'(prod);
          end
        end
        ST_LPMUL: begin
          lp_diff <= 30'(d_clamped) - 30'(lowpass_value);
        end
        ST_LPUPD: begin
          lp_prod = 56'($signed({1'b0, lp_a})) * 56'(lp_diff);
          tmp = 64'(lowpass_value) + rshr64(64'(lp_prod), 24);
          if (tmp > 64'(LP_MAX)) tmp = 64'(LP_MAX);
          if (tmp < 64'(LP_MIN)) tmp = 64'(LP_MIN);
          lowpass_value <= 28'(tmp);
          if (input_rate_hz <= AUDIO) begin
            resample_acc <= '0;
            emit <= 1'b1;
          end else begin
            acc_sum = 64'(resample_acc) + 64'(AUDIO);
            if (acc_sum < 64'(input_rate_hz)) begin
              resample_acc <= 25'(acc_sum);
              emit <= 1'b0;
            end else begin
              resample_acc <= 25'(acc_sum - 64'(input_rate_hz));
              emit <= 1'b1;
            end
          end
        end
        ST_OUT: begin
          if (emit) begin
            tmp = rshr64(64'(lowpass_value), 8);
            out_audio <= (tmp > 64'sd32767) ? 16'sd32767 :
                         (tmp < -64'sd32768) ? -16'sd32768 : 16'(tmp);
            out_valid <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // clamp and coefficient select
  always_comb begin
    d_clamped = (dval > 40'(LP_MAX)) ? LP_MAX : (dval < 40'(LP_MIN)) ? LP_MIN : 28'(dval);
    lp_a = (lowpass_alpha < 25'(DC_MIN)) ? 25'(DC_MIN) :
           (lowpass_alpha > ONE_Q24) ? ONE_Q24 : lowpass_alpha;
    if (md == MODE_CW && lp_a < CW_FLOOR) lp_a = CW_FLOOR;
  end

  `include "iq_audio_demodulator_defines.svh"
  `IQD_ASSERT(a_ready_idle, !q_ready || state == ST_IDLE, "took item while busy")
  `IQD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped")
  `IQD_ASSERT(a_dc_range, dc_level <= 24'd16777215, "dc level out of range")
endmodule
`default_nettype wire

// ===== src/iq_audio_demodulator.sv =====
// iq audio demodulator top level: config registers, front queue, back end
// depends on iqd_pkg, iqd_front, iqd_back
//
// channel | dir | tdata fields (low bit up)
// s_axis  | in  | i_sample[7:0], q_sample[15:8]
// m_axis  | out | audio_sample[15:0]
// cfg     | in  | index 3 bits, data 26 bits
//
// the back end takes one item at a time via prep, the single cordic unit,
// gain, post, low-pass, out; ssb and undefined modes skip cordic and gain
// synchronous reset clears control and filter state only; no clearing pass
// a two-entry queue parts front and back, the output register parts the sink
`default_nettype none
module iq_audio_demodulator #(
  parameter int CORDIC_STAGES = 16,
  parameter int AUDIO_RATE_HZ = 48000
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        s_axis_tvalid,
  output logic       s_axis_tready,
  input  wire [15:0] s_axis_tdata,   // i_sample, q_sample
  output logic       m_axis_tvalid,
  input  wire        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // audio_sample
  input  wire        cfg_valid,
  output logic       cfg_ready,
  input  wire [2:0]  cfg_index,
  input  wire [25:0] cfg_data
);
  import iqd_pkg::*;

  logic [2:0]  demod_mode;
  logic [24:0] input_rate_hz;
  logic [19:0] dc_track_alpha;
  logic [24:0] lowpass_alpha;
  logic [25:0] bfo_phase_step;
  logic        q_valid, q_ready;
  item_t       q_item;
  logic signed [15:0] audio;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      demod_mode     <= MODE_USB;
      input_rate_hz  <= 25'd2000000;
      dc_track_alpha <= 20'd1054;
      lowpass_alpha  <= 25'd1000000;
      bfo_phase_step <= 26'd1503238;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MODE: demod_mode     <= cfg_data[2:0];
        REG_RATE: input_rate_hz  <= cfg_data[24:0];
        REG_DC:   dc_track_alpha <= cfg_data[19:0];
        REG_LP:   lowpass_alpha  <= cfg_data[24:0];
        REG_BFO:  bfo_phase_step <= cfg_data;
        default: ;
      endcase
    end
  end

  iqd_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_i(s_axis_tdata[7:0]), .in_q(s_axis_tdata[15:8]),
    .mode(demod_mode),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
  );

  iqd_back #(.CORDIC_STAGES(CORDIC_STAGES), .AUDIO_RATE_HZ(AUDIO_RATE_HZ)) u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
    .input_rate_hz(input_rate_hz), .dc_track_alpha(dc_track_alpha),
    .lowpass_alpha(lowpass_alpha), .bfo_phase_step(bfo_phase_step),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_audio(audio)
  );

  assign m_axis_tdata = audio;
endmodule
`default_nettype wire
